// ----- design/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg: shared types and codes for the counter machine step unit
// Request layouts, configuration struct, command and status codes.
// ----------------------------------------------------------------------------
package cms_pkg;

  // command codes
  localparam logic [2:0] CMD_JUMP  = 3'd0;
  localparam logic [2:0] CMD_SKIPZ = 3'd1;
  localparam logic [2:0] CMD_DOWN  = 3'd2;
  localparam logic [2:0] CMD_UP    = 3'd3;
  localparam logic [2:0] CMD_STOP  = 3'd4;
  localparam logic [2:0] CMD_LOAD  = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STOPPED  = 3'd1;
  localparam logic [2:0] ST_BAD_JUMP = 3'd2;
  localparam logic [2:0] ST_BAD_REG  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  // configuration register map (index = paddr[3:2])
  localparam int          CFG_ADDR_W           = 4;
  localparam logic [1:0] REG_ALLOW_SIGNED     = 2'd0;
  localparam logic [1:0] REG_RESET_AFTER_STOP = 2'd1;
  localparam logic [1:0] REG_REGISTER_COUNT   = 2'd2;
  localparam logic [1:0] REG_PROGRAM_LINES    = 2'd3;

  localparam logic [4:0]  RST_REGISTER_COUNT = 5'd8;
  localparam logic [10:0] RST_PROGRAM_LINES  = 11'd20;

  typedef struct packed {
    logic        allow_signed;
    logic        reset_after_stop;
    logic [4:0]  register_count;
    logic [10:0] program_lines;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [10:0]        operand;
    logic signed [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         next_line;
    logic signed [31:0] register_value;
    logic [2:0]         status;
  } out_item_t;

endpackage

// ----- design/counter_machine_step.sv -----
// An accepted request goes from the input register, via execute, into the result register.
// Throughput: one request per cycle while out_stall is low; the execute path reads and writes the register file
//   and line counter in the same cycle, so the next request sees the updated state.
// Reset (rst_n low, synchronous): line counter and all registers cleared to zero,
//   configuration back to allow_signed=0, reset_after_stop=0, register_count=8,
//   program_lines=20; both pipeline stages emptied.
// ----------------------------------------------------------------------------
// counter_machine_step: counter machine single-step execution unit
// Input register -> execute logic -> result register, with APB configuration.
// ----------------------------------------------------------------------------
module counter_machine_step #(
  parameter int MAX_REGISTERS = 16,
  parameter int MAX_LINES     = 1024,
  parameter int VALUE_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cms_pkg::in_item_t                 in_item,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output cms_pkg::out_item_t                out_item,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cms_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int LW = ($clog2(MAX_LINES) > 0) ? $clog2(MAX_LINES) : 1;
  localparam int RW = ($clog2(MAX_REGISTERS) > 0) ? $clog2(MAX_REGISTERS) : 1;

  // configuration
  cms_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  // input stage
  logic              s1_valid_r;
  cms_pkg::in_item_t s1_item_r;
  logic              in_take;

  // result stage
  logic               out_valid_r;
  cms_pkg::out_item_t out_item_r;

  // machine state
  logic [LW-1:0]                line_r;
  logic signed [VALUE_BITS-1:0] rf_r [MAX_REGISTERS];

  // execute interface
  logic                         exec_go;
  logic [RW-1:0]                reg_idx;
  logic signed [VALUE_BITS-1:0] reg_cur;
  logic [LW-1:0]                line_nxt;
  logic                         reg_we;
  logic signed [VALUE_BITS-1:0] reg_new;
  cms_pkg::out_item_t           result;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      cms_pkg::REG_ALLOW_SIGNED:     cfg_prdata = 32'(cfg_r.allow_signed);
      cms_pkg::REG_RESET_AFTER_STOP: cfg_prdata = 32'(cfg_r.reset_after_stop);
      cms_pkg::REG_REGISTER_COUNT:   cfg_prdata = 32'(cfg_r.register_count);
      cms_pkg::REG_PROGRAM_LINES:    cfg_prdata = 32'(cfg_r.program_lines);
      default:                       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.allow_signed     <= 1'b0;
      cfg_r.reset_after_stop <= 1'b0;
      cfg_r.register_count   <= cms_pkg::RST_REGISTER_COUNT;
      cfg_r.program_lines    <= cms_pkg::RST_PROGRAM_LINES;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cms_pkg::REG_ALLOW_SIGNED:     cfg_r.allow_signed     <= cfg_pwdata[0];
        cms_pkg::REG_RESET_AFTER_STOP: cfg_r.reset_after_stop <= cfg_pwdata[0];
        cms_pkg::REG_REGISTER_COUNT:   cfg_r.register_count   <= cfg_pwdata[4:0];
        cms_pkg::REG_PROGRAM_LINES:    cfg_r.program_lines    <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Execute whenever the input stage holds a request and the result register
  // is empty or being drained this cycle. The input stage refills in the
  // same cycle it executes, so a full stream runs at one request per clock while out_stall is low.
  assign exec_go  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !exec_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (exec_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------- state
  // Register read at the operand's index; an out-of-range index is never
  // used because the operand check fails first.
  assign reg_cur = rf_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
    end else if (exec_go) begin
      line_r <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_REGISTERS; i++) begin
        rf_r[i] <= '0;
      end
    end else if (exec_go && reg_we) begin
      rf_r[reg_idx] <= reg_new;
    end
  end

  cms_exec #(
    .MAX_REGISTERS (MAX_REGISTERS),
    .MAX_LINES     (MAX_LINES),
    .VALUE_BITS    (VALUE_BITS)
  ) u_exec (
    .cfg      (cfg_r),
    .item     (s1_item_r),
    .line_cur (line_r),
    .reg_idx  (reg_idx),
    .reg_cur  (reg_cur),
    .line_nxt (line_nxt),
    .reg_we   (reg_we),
    .reg_new  (reg_new),
    .result   (result)
  );

`ifndef SYNTHESIS
  // input only backs up when the result register is full and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("in_stall without a blocked result register");

  // an executed request always lands in the result register
  a_exec_lands: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("executed request lost");

  // stops, bad jumps and bad registers clear the line counter when reset_after_stop is set
  a_halt_clears: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && cfg_r.reset_after_stop &&
    (result.status == cms_pkg::ST_STOPPED || result.status == cms_pkg::ST_BAD_JUMP ||
     result.status == cms_pkg::ST_BAD_REG) |=> line_r == '0)
    else $error("line counter not cleared after stop");

  // unknown commands leave the line counter alone
  a_unknown_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && result.status == cms_pkg::ST_UNKNOWN |=> $stable(line_r))
    else $error("unknown command moved the line counter");

  // without signed mode a decrement never writes a negative value
  a_dec_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go && reg_we && !cfg_r.allow_signed && s1_item_r.command == cms_pkg::CMD_DOWN
    |-> !reg_new[VALUE_BITS-1])
    else $error("decrement went negative in unsigned mode");
`endif

endmodule

// ----- design/cms_exec.sv -----
// ----------------------------------------------------------------------------
// cms_exec: single-instruction execute logic
// Decodes one request, checks operands, computes new line and register value.
// ----------------------------------------------------------------------------
module cms_exec #(
  parameter int MAX_REGISTERS = 16,
  parameter int MAX_LINES     = 1024,
  parameter int VALUE_BITS    = 32,
  localparam int LW = ($clog2(MAX_LINES) > 0) ? $clog2(MAX_LINES) : 1,
  localparam int RW = ($clog2(MAX_REGISTERS) > 0) ? $clog2(MAX_REGISTERS) : 1
) (
  input  cms_pkg::cfg_t                cfg,
  input  cms_pkg::in_item_t            item,
  input  logic [LW-1:0]                line_cur,
  output logic [RW-1:0]                reg_idx,
  input  logic signed [VALUE_BITS-1:0] reg_cur,
  output logic [LW-1:0]                line_nxt,
  output logic                         reg_we,
  output logic signed [VALUE_BITS-1:0] reg_new,
  output cms_pkg::out_item_t           result
);

  localparam int LCW = ($clog2(MAX_LINES + 1) > 11) ? $clog2(MAX_LINES + 1) : 11;
  localparam int RCW = ($clog2(MAX_REGISTERS + 1) > 11) ? $clog2(MAX_REGISTERS + 1) : 11;
  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [LCW-1:0]                lines_eff;
  logic [RCW-1:0]                regs_eff;
  logic                          jump_ok;
  logic                          reg_ok;
  logic [10:0]                   opnd_m1;
  logic [LW:0]                   adv_sum;
  logic [LW:0]                   adv_wrap;
  logic [LW-1:0]                 line_adv;
  logic [LW-1:0]                 line_halt;
  logic signed [VALUE_BITS+32:0] load_x;
  logic signed [VALUE_BITS-1:0]  load_sat;
  logic signed [VALUE_BITS-1:0]  dec_val;
  logic signed [VALUE_BITS-1:0]  inc_val;
  logic signed [VALUE_BITS-1:0]  rv;
  logic signed [VALUE_BITS+31:0] rv_x;
  logic [LW+9:0]                 line_x;
  logic [2:0]                    status;

  // effective limits: config values above the build maximum act as the maximum
  assign lines_eff = (LCW'(cfg.program_lines) > LCW'(MAX_LINES)) ?
                     LCW'(MAX_LINES) : LCW'(cfg.program_lines);
  assign regs_eff  = (RCW'(cfg.register_count) > RCW'(MAX_REGISTERS)) ?
                     RCW'(MAX_REGISTERS) : RCW'(cfg.register_count);

  // operand zero is always out of range
  assign jump_ok = (item.operand != 11'd0) && (LCW'(item.operand) <= lines_eff);
  assign reg_ok  = (item.operand != 11'd0) && (RCW'(item.operand) <= regs_eff);
  assign opnd_m1 = item.operand - 11'd1;
  assign reg_idx = RW'(opnd_m1);

  // line advance modulo MAX_LINES: skip on zero adds two, otherwise one
  assign adv_sum  = (LW+1)'(line_cur) +
                    (((item.command == cms_pkg::CMD_SKIPZ) && (reg_cur == '0)) ?
                     (LW+1)'(2) : (LW+1)'(1));
  assign adv_wrap = (adv_sum >= (LW+1)'(MAX_LINES)) ? adv_sum - (LW+1)'(MAX_LINES) : adv_sum;
  assign line_adv = adv_wrap[LW-1:0];

  assign line_halt = cfg.reset_after_stop ? '0 : line_cur;

  // load saturates to the register range
  assign load_x = (VALUE_BITS+33)'(item.load_value);
  always_comb begin
    if (load_x > (VALUE_BITS+33)'(VMAX)) begin
      load_sat = VMAX;
    end else if (load_x < (VALUE_BITS+33)'(VMIN)) begin
      load_sat = VMIN;
    end else begin
      load_sat = load_x[VALUE_BITS-1:0];
    end
  end

  // decrement: saturate at min, clamp negatives to zero when unsigned mode
  always_comb begin
    dec_val = (reg_cur == VMIN) ? VMIN : reg_cur - VALUE_BITS'(1);
    if (dec_val[VALUE_BITS-1] && !cfg.allow_signed) begin
      dec_val = '0;
    end
  end

  assign inc_val = (reg_cur == VMAX) ? VMAX : reg_cur + VALUE_BITS'(1);

  always_comb begin
    line_nxt = line_cur;
    reg_we   = 1'b0;
    reg_new  = reg_cur;
    rv       = '0;
    status   = cms_pkg::ST_OK;
    unique case (item.command) inside
      cms_pkg::CMD_JUMP: begin
        if (jump_ok) begin
          line_nxt = LW'(opnd_m1);
        end else begin
          status   = cms_pkg::ST_BAD_JUMP;
          line_nxt = line_halt;
        end
      end
      cms_pkg::CMD_SKIPZ, cms_pkg::CMD_DOWN, cms_pkg::CMD_UP, cms_pkg::CMD_LOAD: begin
        if (!reg_ok) begin
          status   = cms_pkg::ST_BAD_REG;
          line_nxt = line_halt;
        end else begin
          reg_we = 1'b1;
          unique case (item.command)
            cms_pkg::CMD_DOWN: begin
              reg_new  = dec_val;
              line_nxt = line_adv;
            end
            cms_pkg::CMD_UP: begin
              reg_new  = inc_val;
              line_nxt = line_adv;
            end
            cms_pkg::CMD_LOAD: begin
              reg_new = load_sat;
            end
            default: begin
              // skip if zero: register unchanged
              line_nxt = line_adv;
            end
          endcase
          rv = reg_new;
        end
      end
      cms_pkg::CMD_STOP: begin
        status   = cms_pkg::ST_STOPPED;
        line_nxt = line_halt;
      end
      default: begin
        status = cms_pkg::ST_UNKNOWN;
      end
    endcase
  end

  assign rv_x   = (VALUE_BITS+32)'(rv);
  assign line_x = (LW+10)'(line_nxt);

  assign result.next_line      = line_x[9:0];
  assign result.register_value = rv_x[31:0];
  assign result.status         = status;

endmodule
